// ===== rtl/core/dpt_pkg.sv =====
// Shared types, codes and defaults for the demand-paging page table.
`timescale 1ns / 1ps

package dpt_pkg;

  localparam int PROC_W  = 4;
  localparam int PAGE_W  = 6;
  localparam int FRAME_W = 8;
  localparam int REFS_W  = 8;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 5;

  localparam int MAX_PROCS_DEF             = 16;
  localparam int PAGES_PER_PROC_DEF        = 64;
  localparam int TOTAL_FRAMES_DEF          = 256;
  localparam int TABLE_FRAMES_PER_PROC_DEF = 8;

  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_FAULT  = 2'd1,
    ST_OOM    = 2'd2,
    ST_UNCONF = 2'd3
  } status_t;

  typedef struct packed {
    logic [PROC_W-1:0] process_index;
    logic [PAGE_W-1:0] virtual_page;
  } in_req_t;

  typedef struct packed {
    status_t            status;
    logic [FRAME_W-1:0] physical_frame;
    logic [REFS_W-1:0]  page_ref_count;
    logic [CNT_W-1:0]   process_faults;
    logic [CNT_W-1:0]   process_refs;
  } out_rsp_t;

  // One page-table word
  typedef struct packed {
    logic               valid;
    logic [REFS_W-1:0]  refs;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  // One per-process totals word
  typedef struct packed {
    logic [CNT_W-1:0] faults;
    logic [CNT_W-1:0] refs;
  } tot_t;

  // Update controls from the resolve logic back to the state holder
  typedef struct packed {
    logic commit;
    logic alloc;
    logic set_halt;
  } upd_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== rtl/core/dpt_resolve.sv =====
// Decides hit, fault, out-of-memory or unconfigured for one request and forms write-back data.
`timescale 1ns / 1ps

module dpt_resolve
  import dpt_pkg::*;
#(
  parameter int MAX_PROCS    = MAX_PROCS_DEF,
  parameter int TOTAL_FRAMES = TOTAL_FRAMES_DEF,
  parameter int NF_W         = $clog2(TOTAL_FRAMES_DEF + 1)
) (
  input  logic [PROC_W-1:0] proc,
  input  logic [CFG_W-1:0]  proc_count,
  input  logic              halted,
  input  logic [NF_W-1:0]   next_free,
  input  entry_t            rd_entry,
  input  tot_t              rd_tot,
  output out_rsp_t          rsp,
  output entry_t            wr_entry,
  output tot_t              wr_tot,
  output upd_t              upd
);

  logic unconf;
  logic no_frame;

  assign unconf   = ({1'b0, proc} >= proc_count) || ({2'b00, proc} >= 6'(MAX_PROCS));
  assign no_frame = (next_free >= NF_W'(TOTAL_FRAMES));

  always_comb begin
    rsp      = '0;
    wr_entry = rd_entry;
    wr_tot   = rd_tot;
    upd      = '0;
    priority if (halted) begin
      rsp.status = ST_OOM;
    end else if (unconf) begin
      rsp.status = ST_UNCONF;
    end else if (!rd_entry.valid && no_frame) begin
      rsp.status   = ST_OOM;
      upd.set_halt = 1'b1;
    end else begin
      upd.commit = 1'b1;
      if (!rd_entry.valid) begin
        // fault: take the next frame from the bump pointer
        upd.alloc      = 1'b1;
        wr_entry.valid = 1'b1;
        wr_entry.frame = FRAME_W'(next_free);
        wr_tot.faults  = sat_inc(rd_tot.faults);
        rsp.status     = ST_FAULT;
      end else begin
        rsp.status = ST_HIT;
      end
      wr_entry.refs      = rd_entry.refs + REFS_W'(1);
      wr_tot.refs        = sat_inc(rd_tot.refs);
      rsp.physical_frame = wr_entry.frame;
      rsp.page_ref_count = wr_entry.refs;
      rsp.process_faults = wr_tot.faults;
      rsp.process_refs   = wr_tot.refs;
    end
  end

endmodule

// ===== rtl/core/demand_paging_page_table.sv =====
// Top level of the demand-paging page table: memories, sequencing and handshakes.
`timescale 1ns / 1ps
// Timing: the table read is captured at the accepting edge; execute then resolves the request,
//   writes back and registers the result once the result register is free.
// Sequencing: a request goes idle, then execute; the input is not ready again until it resolves.
//   A result held by out_ready low keeps the block in execute and stalls the input until it leaves.
// Reset: synchronous, active low. After reset a clearing pass over all MAX_PROCS*PAGES_PER_PROC
//   entries (1024 by default) zeroes the entry and totals memories; no request is taken
//   until it ends. Configuration writes are taken at any time.

module demand_paging_page_table
  import dpt_pkg::*;
#(
  parameter int MAX_PROCS             = MAX_PROCS_DEF,
  parameter int PAGES_PER_PROC        = PAGES_PER_PROC_DEF,
  parameter int TOTAL_FRAMES          = TOTAL_FRAMES_DEF,
  parameter int TABLE_FRAMES_PER_PROC = TABLE_FRAMES_PER_PROC_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_req_t          in_req,
  output logic             out_valid,
  input  logic             out_ready,
  output out_rsp_t         out_rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int ENTRY_COUNT = MAX_PROCS * PAGES_PER_PROC;
  localparam int EW          = $clog2(ENTRY_COUNT);
  localparam int PW          = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int NF_W        = $clog2(TOTAL_FRAMES + 1);
  localparam int AW          = 16;   // scratch width for index and base arithmetic

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  // Storage
  entry_t entry_mem [ENTRY_COUNT];
  tot_t   tot_mem   [MAX_PROCS];

  state_t            state_r;
  logic              out_valid_r;
  out_rsp_t          out_rsp_r;
  entry_t            rd_entry_r;
  tot_t              rd_tot_r;
  logic [EW-1:0]     ent_addr_r;
  logic [PROC_W-1:0] proc_r;
  logic [CFG_W-1:0]  proc_count_r;
  logic [NF_W-1:0]   next_free_r;
  logic              any_alloc_r;
  logic              halted_r;
  logic              clr_busy_r;
  logic [EW-1:0]     clr_addr_r;

  logic              in_acc;
  logic              exec_done;
  logic [AW-1:0]     idx_full;
  logic [EW-1:0]     ent_addr_nxt;
  logic [AW-1:0]     base_full;
  logic [NF_W-1:0]   base_nxt;
  out_rsp_t          rsp;
  entry_t            wr_entry;
  tot_t              wr_tot;
  upd_t              upd;

  // Virtual page wraps modulo the page count by repeated compare-subtract steps on 9 bits
  function automatic logic [PAGE_W-1:0] page_wrap(input logic [PAGE_W-1:0] pg);
    logic [8:0] v;
    v = {3'b000, pg};
    for (int i = 0; i < 8; i++) begin
      if (v >= 9'(PAGES_PER_PROC)) begin
        v = v - 9'(PAGES_PER_PROC);
      end
    end
    return v[PAGE_W-1:0];
  endfunction

  assign in_ready  = (state_r == S_IDLE) && !clr_busy_r;
  assign in_acc    = in_valid && in_ready;
  assign exec_done = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign cfg_ready = 1'b1;

  // Flat entry index: process row plus wrapped page
  assign idx_full     = AW'(in_req.process_index) * AW'(PAGES_PER_PROC)
                      + AW'(page_wrap(in_req.virtual_page));
  assign ent_addr_nxt = idx_full[EW-1:0];

  // Table-frame base for a newly written process count, clipped at the pool size
  assign base_full = AW'(cfg_data) * AW'(TABLE_FRAMES_PER_PROC);
  assign base_nxt  = (base_full > AW'(TOTAL_FRAMES)) ? NF_W'(TOTAL_FRAMES)
                                                     : base_full[NF_W-1:0];

  dpt_resolve #(
    .MAX_PROCS    (MAX_PROCS),
    .TOTAL_FRAMES (TOTAL_FRAMES),
    .NF_W         (NF_W)
  ) u_resolve (
    .proc       (proc_r),
    .proc_count (proc_count_r),
    .halted     (halted_r),
    .next_free  (next_free_r),
    .rd_entry   (rd_entry_r),
    .rd_tot     (rd_tot_r),
    .rsp        (rsp),
    .wr_entry   (wr_entry),
    .wr_tot     (wr_tot),
    .upd        (upd)
  );

  // Entry memory: clearing sweep, then write-back of resolved requests
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      entry_mem[clr_addr_r] <= '0;
    end else if (exec_done && upd.commit) begin
      entry_mem[ent_addr_r] <= wr_entry;
    end
    if (in_acc) begin
      rd_entry_r <= entry_mem[ent_addr_nxt];
    end
  end

  // Per-process totals memory, swept alongside the entries
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      if (AW'(clr_addr_r) < AW'(MAX_PROCS)) begin
        tot_mem[clr_addr_r[PW-1:0]] <= '0;
      end
    end else if (exec_done && upd.commit) begin
      tot_mem[PW'(AW'(proc_r))] <= wr_tot;
    end
    if (in_acc) begin
      rd_tot_r <= tot_mem[PW'(AW'(in_req.process_index))];
    end
  end

  // Request capture (payload, no reset)
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ent_addr_r <= ent_addr_nxt;
      proc_r     <= in_req.process_index;
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == EW'(ENTRY_COUNT - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + EW'(1);
      end
    end
  end

  // Configuration, frame pointer and halt flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_count_r <= '0;
      next_free_r  <= '0;
      any_alloc_r  <= 1'b0;
      halted_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        proc_count_r <= cfg_data;
      end
      if (exec_done && upd.alloc) begin
        next_free_r <= next_free_r + NF_W'(1);
        any_alloc_r <= 1'b1;
      end else if (cfg_valid && cfg_ready && !any_alloc_r) begin
        // base only moves while nothing has been handed out
        next_free_r <= base_nxt;
      end
      if (exec_done && upd.set_halt) begin
        halted_r <= 1'b1;
      end
    end
  end

  // Sequencer with the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (out_valid_r && out_ready) begin
            out_valid_r <= 1'b0;
          end
          if (in_acc) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          // hold the read data until the result register is free; a result leaving
          // this cycle is replaced straight away
          if (exec_done) begin
            out_valid_r <= 1'b1;
            out_rsp_r   <= rsp;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag dropped without reset");

  // Each allocation advances the frame pointer by exactly one
  a_alloc_bump: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_done && upd.alloc && !(cfg_valid && cfg_ready)) |=>
      (next_free_r == $past(next_free_r) + NF_W'(1)))
    else $error("frame pointer did not advance on allocation");

  // No table write-back may overlap the clearing sweep
  a_no_exec_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (state_r == S_IDLE))
    else $error("request in flight during clearing pass");

  // A fault result always comes with a valid allocation recorded
  a_fault_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_done && (rsp.status == ST_FAULT)) |=> any_alloc_r)
    else $error("fault reported without allocation");

endmodule
